/* rtl/afsk_pkg.sv */
// Shared types, sizes and reset values for the AFSK NRZI bit-stuffing modulator.
// Depends on nothing; every other file imports it.
package afsk_pkg;

   // Sizing of the datapath.
   localparam int PHASE_WIDTH         = 24;
   localparam int TWIDDLE_WIDTH       = 18;
   localparam int MAX_SAMPLES_PER_BIT = 64;

   // Fraction bits of the twiddle and of the phasor.
   localparam int TW_FRAC = TWIDDLE_WIDTH - 2;
   localparam int PH_FRAC = PHASE_WIDTH - 1;

   // Fixed field widths.
   localparam int COEF_WIDTH      = 17;
   localparam int SPB_WIDTH       = 7;
   localparam int SAMPLE_WIDTH    = 16;
   localparam int CMD_WIDTH       = 2;
   localparam int BYTE_BITS       = 8;
   localparam int STUFF_RUN       = 5;
   localparam int ONES_WIDTH      = 3;
   localparam int CSR_DATA_WIDTH  = 17;
   localparam int CSR_INDEX_WIDTH = 3;

   // 32767 is 2^15 - 1, so the full-scale product is a shift and a subtract.
   localparam int FULL_SCALE_SHIFT = 15;

   // Counter widths.
   localparam int BITS_LEFT_WIDTH = $clog2(BYTE_BITS + 1);
   localparam int POS_WIDTH       = $clog2(MAX_SAMPLES_PER_BIT);
   localparam int CNT_WIDTH       = POS_WIDTH + 1;
   localparam int CMP_WIDTH       = (CNT_WIDTH > SPB_WIDTH) ? CNT_WIDTH : SPB_WIDTH;

   // Reset values of the registers and of the phasor.
   localparam logic [SPB_WIDTH-1:0]         SPB_RESET       = SPB_WIDTH'(40);
   localparam logic signed [COEF_WIDTH-1:0] TONE0_COS_RESET = COEF_WIDTH'(64729);
   localparam logic signed [COEF_WIDTH-1:0] TONE0_SIN_RESET = COEF_WIDTH'(10252);
   localparam logic signed [COEF_WIDTH-1:0] TONE1_COS_RESET = COEF_WIDTH'(62837);
   localparam logic signed [COEF_WIDTH-1:0] TONE1_SIN_RESET = COEF_WIDTH'(18614);
   localparam logic [PHASE_WIDTH-1:0] PHASE_IM_RESET =
      PHASE_WIDTH'(((64'd1 << PH_FRAC) * 64'd4) / 64'd5);

   // Command codes of an input word.
   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_LOAD  = 2'd0,
      CMD_TICK  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_SPB       = 3'd0,
      REG_TONE0_COS = 3'd1,
      REG_TONE0_SIN = 3'd2,
      REG_TONE1_COS = 3'd3,
      REG_TONE1_SIN = 3'd4
   } csr_index_type;

   // One registered input word.
   typedef struct packed {
      logic                 valid;
      cmd_type              cmd;
      logic [BYTE_BITS-1:0] data_byte;
      logic                 stuff_enable;
   } req_item_type;

   // One tone's rotation step.
   typedef struct packed {
      logic signed [COEF_WIDTH-1:0] cos_val;
      logic signed [COEF_WIDTH-1:0] sin_val;
   } twiddle_type;

   // Sequencer to rotator control.
   typedef struct packed {
      logic rotate;
      logic tone_select;
   } rot_ctrl_type;

   // Sequencer flags for the result word.
   typedef struct packed {
      logic sample_valid;
      logic load_accepted;
      logic want_byte;
      logic underrun;
   } seq_status_type;

endpackage

/* rtl/afsk_req_reg.sv */
// Input register of the modulator: holds one request word until the core takes it.
// Depends on afsk_pkg.
module afsk_req_reg (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [afsk_pkg::CMD_WIDTH-1:0]   req_cmd,
   input  logic [afsk_pkg::BYTE_BITS-1:0]   req_data_byte,
   input  logic                             req_stuff_enable,
   input  logic                             take,
   output afsk_pkg::req_item_type           item
);
   import afsk_pkg::*;

   logic                 valid_ff;
   cmd_type              cmd_ff;
   logic [BYTE_BITS-1:0] data_byte_ff;
   logic                 stuff_enable_ff;

   // The register is free when empty or when its word leaves this cycle.
   assign req_ready = !valid_ff || take;

   // Occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
   end

   // Payload.
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         cmd_ff          <= cmd_type'(req_cmd);
         data_byte_ff    <= req_data_byte;
         stuff_enable_ff <= req_stuff_enable;
      end
   end

   assign item.valid        = valid_ff;
   assign item.cmd          = cmd_ff;
   assign item.data_byte    = data_byte_ff;
   assign item.stuff_enable = stuff_enable_ff;

endmodule

/* rtl/afsk_bit_seq.sv */
// Bit sequencer: holding register, HDLC zero insertion, NRZI tone and sample pacing.
// Depends on afsk_pkg.
module afsk_bit_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             fire,
   input  afsk_pkg::req_item_type           item,
   input  logic [afsk_pkg::SPB_WIDTH-1:0]   samples_per_bit,
   output afsk_pkg::rot_ctrl_type           rot_ctrl,
   output afsk_pkg::seq_status_type         status
);
   import afsk_pkg::*;

   logic [BYTE_BITS-1:0]       bit_shift_ff,     bit_shift_in;
   logic [BITS_LEFT_WIDTH-1:0] bits_left_ff,     bits_left_in;
   logic                       stuff_latched_ff, stuff_latched_in;
   logic                       stuff_pending_ff, stuff_pending_in;
   logic [ONES_WIDTH-1:0]      ones_count_ff,    ones_count_in;
   logic                       tone_select_ff,   tone_select_in;
   logic                       bit_active_ff,    bit_active_in;
   logic [POS_WIDTH-1:0]       sample_pos_ff,    sample_pos_in;

   logic                  have_bit;
   logic                  tx_bit;
   logic [ONES_WIDTH-1:0] ones_inc;
   logic [CMP_WIDTH-1:0]  spb_ext;
   logic [CMP_WIDTH-1:0]  spb_eff;
   logic [CNT_WIDTH-1:0]  pos_inc;

   // Clamp the configured bit length to the supported range.
   always_comb begin
      spb_ext = CMP_WIDTH'(samples_per_bit);
      priority if (spb_ext == '0) begin
         spb_eff = CMP_WIDTH'(1);
      end else if (spb_ext > CMP_WIDTH'(MAX_SAMPLES_PER_BIT)) begin
         spb_eff = CMP_WIDTH'(MAX_SAMPLES_PER_BIT);
      end else begin
         spb_eff = spb_ext;
      end
   end

   // Next state and result flags for the word in the input register.
   always_comb begin
      bit_shift_in     = bit_shift_ff;
      bits_left_in     = bits_left_ff;
      stuff_latched_in = stuff_latched_ff;
      stuff_pending_in = stuff_pending_ff;
      ones_count_in    = ones_count_ff;
      tone_select_in   = tone_select_ff;
      bit_active_in    = bit_active_ff;
      sample_pos_in    = sample_pos_ff;
      have_bit         = 1'b0;
      tx_bit           = 1'b0;
      ones_inc         = ones_count_ff + ONES_WIDTH'(1);
      pos_inc          = CNT_WIDTH'(sample_pos_ff) + CNT_WIDTH'(1);
      status           = '0;
      rot_ctrl.rotate  = 1'b0;

      unique case (item.cmd)
         CMD_LOAD: begin
            if (bits_left_ff == '0 && !stuff_pending_ff) begin
               bit_shift_in         = item.data_byte;
               bits_left_in         = BITS_LEFT_WIDTH'(BYTE_BITS);
               stuff_latched_in     = item.stuff_enable;
               status.load_accepted = 1'b1;
            end
         end
         CMD_CLEAR: begin
            ones_count_in = '0;
         end
         CMD_TICK: begin
            // At a bit boundary pick the next bit: stuffed zero first, then data.
            if (!bit_active_ff) begin
               priority if (stuff_pending_ff) begin
                  stuff_pending_in = 1'b0;
                  have_bit         = 1'b1;
               end else if (bits_left_ff != '0) begin
                  tx_bit       = bit_shift_ff[0];
                  bit_shift_in = bit_shift_ff >> 1;
                  bits_left_in = bits_left_ff - BITS_LEFT_WIDTH'(1);
                  have_bit     = 1'b1;
                  if (stuff_latched_ff && tx_bit) begin
                     if (ones_inc == ONES_WIDTH'(STUFF_RUN)) begin
                        stuff_pending_in = 1'b1;
                        ones_count_in    = '0;
                     end else begin
                        ones_count_in = ones_inc;
                     end
                  end
                  if (!tx_bit) begin
                     ones_count_in = '0;
                  end
               end else begin
                  status.underrun = 1'b1;
               end
               // A zero bit flips the NRZI tone.
               if (have_bit) begin
                  if (!tx_bit) begin
                     tone_select_in = !tone_select_ff;
                  end
                  pos_inc = CNT_WIDTH'(1);
               end
            end
            // Emit one sample while a bit is on the air.
            if (bit_active_ff || have_bit) begin
               rot_ctrl.rotate     = 1'b1;
               status.sample_valid = 1'b1;
               if (CMP_WIDTH'(pos_inc) >= spb_eff) begin
                  sample_pos_in = '0;
                  bit_active_in = 1'b0;
               end else begin
                  sample_pos_in = POS_WIDTH'(pos_inc);
                  bit_active_in = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase

      rot_ctrl.rotate      = rot_ctrl.rotate && fire;
      rot_ctrl.tone_select = tone_select_in;
      status.want_byte     = (bits_left_in == '0) && !stuff_pending_in;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_shift_ff     <= '0;
         bits_left_ff     <= '0;
         stuff_latched_ff <= 1'b0;
         stuff_pending_ff <= 1'b0;
         ones_count_ff    <= '0;
         tone_select_ff   <= 1'b0;
         bit_active_ff    <= 1'b0;
         sample_pos_ff    <= '0;
      end else if (fire) begin
         bit_shift_ff     <= bit_shift_in;
         bits_left_ff     <= bits_left_in;
         stuff_latched_ff <= stuff_latched_in;
         stuff_pending_ff <= stuff_pending_in;
         ones_count_ff    <= ones_count_in;
         tone_select_ff   <= tone_select_in;
         bit_active_ff    <= bit_active_in;
         sample_pos_ff    <= sample_pos_in;
      end
   end

   // A pending stuffed zero always follows a run that reset the ones counter.
   a_pending_ones_clear: assert property (@(posedge clock) disable iff (reset)
      stuff_pending_ff |-> ones_count_ff == '0)
      else $error("ones counter nonzero while a stuffed zero is pending");

   a_bits_left_range: assert property (@(posedge clock) disable iff (reset)
      bits_left_ff <= BITS_LEFT_WIDTH'(BYTE_BITS))
      else $error("bits left exceeds one byte");

   a_pos_idle_zero: assert property (@(posedge clock) disable iff (reset)
      !bit_active_ff |-> sample_pos_ff == '0)
      else $error("sample position nonzero between bits");

endmodule

/* rtl/afsk_rotator.sv */
// Phasor rotator: holds the Q1.23 phasor, rotates it by the selected tone step,
// and scales the new real part to an audio sample. Depends on afsk_pkg.
module afsk_rotator (
   input  logic                                    clock,
   input  logic                                    reset,
   input  afsk_pkg::rot_ctrl_type                  rot_ctrl,
   input  afsk_pkg::twiddle_type                   tone0,
   input  afsk_pkg::twiddle_type                   tone1,
   output logic signed [afsk_pkg::SAMPLE_WIDTH-1:0] sample
);
   import afsk_pkg::*;

   localparam int PROD_W  = COEF_WIDTH + PHASE_WIDTH;
   localparam int SUM_W   = PROD_W + 1;
   localparam int SHIFT_W = SUM_W - TW_FRAC;
   localparam int SMP_W   = PHASE_WIDTH + FULL_SCALE_SHIFT + 1;

   logic signed [PHASE_WIDTH-1:0] phase_re_ff, phase_re_in;
   logic signed [PHASE_WIDTH-1:0] phase_im_ff, phase_im_in;

   twiddle_type               tw;
   logic signed [PROD_W-1:0]  p_cr, p_si, p_ci, p_sr;
   logic signed [SUM_W-1:0]   sum_re, sum_im;
   logic signed [SHIFT_W-1:0] sh_re, sh_im;
   logic signed [SMP_W-1:0]   smp_prod, smp_biased;

   // Clamp a shifted product sum to the phasor range.
   function automatic logic signed [PHASE_WIDTH-1:0] sat_phase(
      input logic signed [SHIFT_W-1:0] v
   );
      logic [SHIFT_W-PHASE_WIDTH:0] top;
      top = v[SHIFT_W-1:PHASE_WIDTH-1];
      if ((&top) || !(|top)) begin
         return v[PHASE_WIDTH-1:0];
      end else if (v[SHIFT_W-1]) begin
         return {1'b1, {(PHASE_WIDTH-1){1'b0}}};
      end else begin
         return {1'b0, {(PHASE_WIDTH-1){1'b1}}};
      end
   endfunction

   assign tw = rot_ctrl.tone_select ? tone1 : tone0;

   // Complex multiply by the tone step, floored to Q1.23 and saturated.
   assign p_cr   = tw.cos_val * phase_re_ff;
   assign p_si   = tw.sin_val * phase_im_ff;
   assign p_ci   = tw.cos_val * phase_im_ff;
   assign p_sr   = tw.sin_val * phase_re_ff;
   assign sum_re = SUM_W'(p_cr) - SUM_W'(p_si);
   assign sum_im = SUM_W'(p_ci) + SUM_W'(p_sr);
   assign sh_re  = SHIFT_W'(sum_re >>> TW_FRAC);
   assign sh_im  = SHIFT_W'(sum_im >>> TW_FRAC);

   assign phase_re_in = sat_phase(sh_re);
   assign phase_im_in = sat_phase(sh_im);

   // Sample is 32767 times the real part, truncated toward zero.
   assign smp_prod   = (SMP_W'(phase_re_in) <<< FULL_SCALE_SHIFT) - SMP_W'(phase_re_in);
   assign smp_biased = smp_prod
                       + {{(SMP_W-PH_FRAC){1'b0}}, {PH_FRAC{smp_prod[SMP_W-1]}}};
   assign sample     = SAMPLE_WIDTH'(smp_biased >>> PH_FRAC);

   // Phasor state advances only on an emitted sample.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_re_ff <= '0;
         phase_im_ff <= PHASE_IM_RESET;
      end else if (rot_ctrl.rotate) begin
         phase_re_ff <= phase_re_in;
         phase_im_ff <= phase_im_in;
      end
   end

   a_phase_hold: assert property (@(posedge clock) disable iff (reset)
      !rot_ctrl.rotate |=> $stable(phase_re_ff) && $stable(phase_im_ff))
      else $error("phasor moved without an emitted sample");

endmodule

/* rtl/afsk_nrzi_bitstuff_modulator.sv */
// AFSK modulator with NRZI coding and HDLC zero insertion: top level.
// Depends on afsk_pkg, afsk_req_reg, afsk_bit_seq and afsk_rotator.
//
// Every request word (load a byte, sample tick, clear the ones counter) yields
// exactly one result word. A word taken from the input sits in the input
// register, is processed once the result register is empty or being drained,
// and is then registered into the result register; while results are drained
// the block sustains one word per clock; the phasor feedback through the four
// rotation multipliers and the saturation is the path that sets this rate.
// While a finished result waits on the output, the input register takes at
// most one more word and then holds off the input until the result is taken.
// A sample tick at a bit boundary with no byte or stuffed zero left reports
// underrun, gives no sample and leaves the phasor alone. Configuration writes
// take effect at once and are meant for when no word is in flight.
module afsk_nrzi_bitstuff_modulator (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [afsk_pkg::CMD_WIDTH-1:0]           req_cmd,
   input  logic [afsk_pkg::BYTE_BITS-1:0]           req_data_byte,
   input  logic                                     req_stuff_enable,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [afsk_pkg::SAMPLE_WIDTH-1:0] rsp_sample,
   output logic                                     rsp_sample_valid,
   output logic                                     rsp_load_accepted,
   output logic                                     rsp_want_byte,
   output logic                                     rsp_underrun,
   input  logic                                     csr_write_enable,
   input  logic [afsk_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [afsk_pkg::CSR_DATA_WIDTH-1:0]      csr_write_data
);
   import afsk_pkg::*;

   // Configuration registers.
   logic [SPB_WIDTH-1:0] spb_ff;
   twiddle_type          tone0_ff;
   twiddle_type          tone1_ff;

   req_item_type   item;
   rot_ctrl_type   rot_ctrl;
   seq_status_type status;
   logic           fire;
   logic signed [SAMPLE_WIDTH-1:0] sample_raw;

   logic                           rsp_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_ff;
   logic                           rsp_sample_valid_ff;
   logic                           rsp_load_accepted_ff;
   logic                           rsp_want_byte_ff;
   logic                           rsp_underrun_ff;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         spb_ff           <= SPB_RESET;
         tone0_ff.cos_val <= TONE0_COS_RESET;
         tone0_ff.sin_val <= TONE0_SIN_RESET;
         tone1_ff.cos_val <= TONE1_COS_RESET;
         tone1_ff.sin_val <= TONE1_SIN_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            REG_SPB:       spb_ff           <= csr_write_data[SPB_WIDTH-1:0];
            REG_TONE0_COS: tone0_ff.cos_val <= csr_write_data[COEF_WIDTH-1:0];
            REG_TONE0_SIN: tone0_ff.sin_val <= csr_write_data[COEF_WIDTH-1:0];
            REG_TONE1_COS: tone1_ff.cos_val <= csr_write_data[COEF_WIDTH-1:0];
            REG_TONE1_SIN: tone1_ff.sin_val <= csr_write_data[COEF_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // A word is processed when the result register is empty or being drained.
   assign fire = item.valid && (!rsp_valid_ff || rsp_ready);

   afsk_req_reg u_req_reg (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_data_byte    (req_data_byte),
      .req_stuff_enable (req_stuff_enable),
      .take             (fire),
      .item             (item)
   );

   afsk_bit_seq u_bit_seq (
      .clock           (clock),
      .reset           (reset),
      .fire            (fire),
      .item            (item),
      .samples_per_bit (spb_ff),
      .rot_ctrl        (rot_ctrl),
      .status          (status)
   );

   afsk_rotator u_rotator (
      .clock    (clock),
      .reset    (reset),
      .rot_ctrl (rot_ctrl),
      .tone0    (tone0_ff),
      .tone1    (tone1_ff),
      .sample   (sample_raw)
   );

   // Result register occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload; the sample reads zero when no sample was made.
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_sample_ff        <= status.sample_valid ? sample_raw : '0;
         rsp_sample_valid_ff  <= status.sample_valid;
         rsp_load_accepted_ff <= status.load_accepted;
         rsp_want_byte_ff     <= status.want_byte;
         rsp_underrun_ff      <= status.underrun;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample        = rsp_sample_ff;
   assign rsp_sample_valid  = rsp_sample_valid_ff;
   assign rsp_load_accepted = rsp_load_accepted_ff;
   assign rsp_want_byte     = rsp_want_byte_ff;
   assign rsp_underrun      = rsp_underrun_ff;

   a_fire_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("processed word did not reach the result register");

   a_underrun_no_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_underrun_ff |-> !rsp_sample_valid_ff && rsp_sample_ff == '0)
      else $error("underrun word carries a sample");

endmodule
